// ===== src/ltbf_pkg.sv =====
// shared types and constants for the linear trend budget forecast block
package ltbf_pkg;

  localparam int MAX_DAYS    = 512;
  localparam int MAX_HORIZON = 365;
  localparam int ADDR_W      = $clog2(MAX_DAYS);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int COST_W      = 32;
  localparam int SUM_W       = 41;
  localparam int SXY_W       = 50;
  localparam int BUDGET_W    = 48;
  localparam int HOR_W       = 9;
  localparam int OUT_W       = 48;
  localparam int R2_W        = 17;
  localparam int ALU_W       = 106;
  localparam int MB_W        = 56;
  localparam int Q_W         = 56;
  localparam int FIT_W       = 56;
  localparam int FC_W        = 64;
  localparam int INT_SHIFT   = 54;
  localparam int INT_STEPS   = INT_SHIFT + 1;
  localparam int R2_STEPS    = R2_W + 1;
  localparam int STEP_W      = 7;

  // configuration register indexes
  localparam logic REG_BUDGET  = 1'b0;
  localparam logic REG_HORIZON = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_P_CALC,
    ST_IC_BASE,
    ST_NSQ,
    ST_SL_DIV,
    ST_SL_DONE,
    ST_IC_DIV,
    ST_IC_DONE,
    ST_RD,
    ST_RD_W,
    ST_ACC,
    ST_NSYY,
    ST_SYSY,
    ST_TCALC,
    ST_PP,
    ST_R2_DIV,
    ST_R2_DONE,
    ST_FC_INIT,
    ST_FC_SET,
    ST_FC_STEP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ltbf_state_t;

endpackage

// ===== src/ltbf_ram.sv =====
// generic single-port-write, registered-read memory
module ltbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/linear_trend_budget_forecast_core.sv =====
// top level: sample store, shared shift-add / restoring-divide unit and sequencer
//
// Usage: daily costs arrive on the input channel (in_valid/in_ready) with
// last_day marking the final sample of a series. Each sample is stored and
// summed as it is accepted; in_ready stays high while samples stream in.
// On the last sample the block drops in_ready and, given at least three samples,
// runs its sequencer: a least-squares fit (slope, intercept), an R squared pass
// over the store and a walk over forecast days until the running total reaches
// budget_limit or the forecast horizon ends. Fit products and all quotients go
// through one shared unit that retires one multiplier bit or one quotient bit
// per cycle; each sample's cost times day index product has its own multiplier.
// One result transaction per series is held in an output register on
// out_valid/out_ready; the sequencer waits for that register to empty before
// it writes the next result, and stalls on out_ready never lose a result.
// Samples beyond 512 are dropped and flagged. Reset clears the series state,
// sets budget_limit to 0 and forecast_horizon to 365; the store needs no clearing.
module linear_trend_budget_forecast_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [ltbf_pkg::BUDGET_W-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ltbf_pkg::COST_W-1:0]    daily_cost,
  input  logic                           last_day,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           fit_valid,
  output logic signed [ltbf_pkg::OUT_W-1:0] trend_slope,
  output logic signed [ltbf_pkg::OUT_W-1:0] trend_intercept,
  output logic [ltbf_pkg::R2_W-1:0]      fit_r2,
  output logic                           budget_exhausted,
  output logic [ltbf_pkg::HOR_W-1:0]     exhaustion_day,
  output logic [ltbf_pkg::CNT_W-1:0]     samples_used,
  output logic                           overflow_flag
);
  import ltbf_pkg::*;

  ltbf_state_t state, state_next, ret;

  logic [BUDGET_W-1:0] budget_limit;
  logic [HOR_W-1:0]    forecast_horizon;

  logic [CNT_W-1:0]  n;
  logic [SUM_W-1:0]  sy;
  logic [SXY_W-1:0]  sxy;
  logic              dropped;

  logic [ALU_W-1:0]  ma, macc, rem, dv, syy, t, dr;
  logic [MB_W-1:0]   mb;
  logic [Q_W-1:0]    q;
  logic [STEP_W-1:0] steps;

  logic [51:0]       pmag;
  logic              pneg;
  logic [54:0]       imag;
  logic              ineg;
  logic [17:0]       nsq1;
  logic signed [FIT_W-1:0] slope, icpt;
  logic [R2_W-1:0]   r2;
  logic signed [FC_W-1:0] p;
  logic [FC_W-1:0]   total;
  logic [HOR_W-1:0]  day, hor;
  logic              hit;
  logic [CNT_W-1:0]  idx;

  logic              ram_we;
  logic [COST_W-1:0] ram_rdata;

  logic              in_fire, store_ok, div_bit;
  logic [ALU_W-1:0]  rem_sub;
  logic [FC_W-1:0]   tot_n;
  logic signed [FC_W-1:0] pos;
  logic [52:0]       base, p3;
  logic [FIT_W-1:0]  slope_mag;
  logic signed [FC_W-1:0] sn;
  logic [COST_W+CNT_W-1:0] cost_idx;

  assign in_fire  = in_valid && in_ready;
  assign store_ok = n < CNT_W'(MAX_DAYS);
  assign div_bit  = rem >= dv;
  assign rem_sub  = div_bit ? rem - dv : rem;
  assign pos      = (p > 0) ? p : '0;
  assign tot_n    = total + FC_W'(pos);
  assign base     = macc[52:0];
  assign p3       = 53'(pmag) + {pmag, 1'b0};
  assign slope_mag = slope[FIT_W-1] ? FIT_W'(-slope) : FIT_W'(slope);
  assign sn       = macc[FC_W-1:0];
  assign hor      = (forecast_horizon > HOR_W'(MAX_HORIZON)) ? HOR_W'(MAX_HORIZON)
                                                             : forecast_horizon;
  assign cost_idx = {{CNT_W{1'b0}}, daily_cost} * {{COST_W{1'b0}}, n};

  ltbf_ram #(
    .WIDTH (COST_W),
    .DEPTH (MAX_DAYS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n[ADDR_W-1:0]),
    .wdata (daily_cost),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_fire && last_day) state_next = ST_START;
      ST_START:   state_next = (n < CNT_W'(3)) ? ST_DONE : ST_MUL;
      ST_P_CALC, ST_IC_BASE, ST_NSQ, ST_SL_DONE, ST_RD_W, ST_NSYY, ST_SYSY,
      ST_PP, ST_FC_INIT: begin
        if (state == ST_FC_INIT && hor == '0) state_next = ST_DONE;
        else state_next = ST_MUL;
      end
      ST_SL_DIV, ST_IC_DIV, ST_R2_DIV: state_next = ST_DIV;
      ST_IC_DONE: state_next = ST_RD;
      ST_RD:      state_next = ST_RD_W;
      ST_ACC:     state_next = (idx + 1'b1 == n) ? ST_NSYY : ST_RD;
      ST_TCALC:   state_next = (t == macc) ? ST_FC_INIT : ST_MUL;
      ST_R2_DONE: state_next = ST_FC_INIT;
      ST_FC_SET:  state_next = ST_FC_STEP;
      ST_FC_STEP: if (tot_n >= FC_W'(budget_limit) || day == hor) state_next = ST_DONE;
      ST_MUL:     if (mb == '0) state_next = ret;
      ST_DIV:     if (steps == STEP_W'(1)) state_next = ret;
      ST_DONE:    if (!out_valid) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // handshake and store controls
  always_comb begin
    in_ready = (state == ST_IDLE);
    ram_we   = in_fire && store_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      ret              <= ST_IDLE;
      budget_limit     <= '0;
      forecast_horizon <= HOR_W'(MAX_HORIZON);
      n                <= '0;
      sy               <= '0;
      sxy              <= '0;
      dropped          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == REG_BUDGET) budget_limit <= cfg_data;
        else forecast_horizon <= cfg_data[HOR_W-1:0];
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (store_ok) begin
              n   <= n + 1'b1;
              sy  <= sy + SUM_W'(daily_cost);
              sxy <= sxy + SXY_W'(cost_idx);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        ST_START: begin
          slope <= '0;
          icpt  <= '0;
          r2    <= '0;
          hit   <= 1'b0;
          day   <= '0;
          ma    <= ALU_W'(sy);
          mb    <= MB_W'(n - 1'b1);
          macc  <= '0;
          ret   <= ST_P_CALC;
        end
        ST_P_CALC: begin
          if ({sxy, 1'b0} < macc[50:0]) begin
            pneg <= 1'b1;
            pmag <= 52'(macc[50:0] - {sxy, 1'b0});
          end else begin
            pneg <= 1'b0;
            pmag <= 52'({sxy, 1'b0} - macc[50:0]);
          end
          ma   <= ALU_W'(sy);
          mb   <= MB_W'(n + 1'b1);
          macc <= '0;
          ret  <= ST_IC_BASE;
        end
        ST_IC_BASE: begin
          if (pneg) begin
            ineg <= 1'b0;
            imag <= 55'(base) + 55'(p3);
          end else if (base >= p3) begin
            ineg <= 1'b0;
            imag <= 55'(base - p3);
          end else begin
            ineg <= 1'b1;
            imag <= 55'(p3 - base);
          end
          ma   <= ALU_W'(n);
          mb   <= MB_W'(n);
          macc <= '0;
          ret  <= ST_NSQ;
        end
        ST_NSQ: begin
          // n squared reaches 2^18 for a full store
          nsq1 <= 18'(macc[18:0] - 19'd1);
          ma   <= ALU_W'(macc[18:0] - 19'd1);
          mb   <= MB_W'(n);
          macc <= '0;
          ret  <= ST_SL_DIV;
        end
        ST_SL_DIV: begin
          // 6|P| plus half the divisor gives round to nearest
          rem   <= ALU_W'({pmag, 2'b00}) + ALU_W'({pmag, 1'b0}) + (macc >> 1);
          dv    <= macc << INT_SHIFT;
          q     <= '0;
          steps <= STEP_W'(INT_STEPS);
          ret   <= ST_SL_DONE;
        end
        ST_SL_DONE: begin
          slope <= pneg ? -$signed(q) : $signed(q);
          ma    <= ALU_W'(n + 1'b1);
          mb    <= MB_W'(n);
          macc  <= '0;
          ret   <= ST_IC_DIV;
        end
        ST_IC_DIV: begin
          rem   <= ALU_W'(imag) + (macc >> 1);
          dv    <= macc << INT_SHIFT;
          q     <= '0;
          steps <= STEP_W'(INT_STEPS);
          ret   <= ST_IC_DONE;
        end
        ST_IC_DONE: begin
          icpt <= ineg ? -$signed(q) : $signed(q);
          syy  <= '0;
          idx  <= '0;
        end
        ST_RD_W: begin
          ma   <= ALU_W'(ram_rdata);
          mb   <= MB_W'(ram_rdata);
          macc <= '0;
          ret  <= ST_ACC;
        end
        ST_ACC: begin
          syy <= syy + macc;
          idx <= idx + 1'b1;
        end
        ST_NSYY: begin
          ma   <= syy;
          mb   <= MB_W'(n);
          macc <= '0;
          ret  <= ST_SYSY;
        end
        ST_SYSY: begin
          t    <= macc;
          ma   <= ALU_W'(sy);
          mb   <= MB_W'(sy);
          macc <= '0;
          ret  <= ST_TCALC;
        end
        ST_TCALC: begin
          // zero variance leaves r squared at zero
          ma   <= t - macc;
          mb   <= MB_W'(nsq1);
          macc <= '0;
          ret  <= ST_PP;
        end
        ST_PP: begin
          dr   <= macc;
          ma   <= ALU_W'(pmag);
          mb   <= MB_W'(pmag);
          macc <= '0;
          ret  <= ST_R2_DIV;
        end
        ST_R2_DIV: begin
          rem   <= macc + {macc[ALU_W-2:0], 1'b0};
          dv    <= dr;
          q     <= '0;
          steps <= STEP_W'(R2_STEPS);
          ret   <= ST_R2_DONE;
        end
        ST_R2_DONE: begin
          r2 <= R2_W'((19'(q[17:0]) + 1'b1) >> 1);
        end
        ST_FC_INIT: begin
          ma   <= ALU_W'(slope_mag);
          mb   <= MB_W'(n);
          macc <= '0;
          ret  <= ST_FC_SET;
        end
        ST_FC_SET: begin
          p     <= (slope[FIT_W-1] ? -sn : sn) + FC_W'(icpt);
          total <= FC_W'(sy);
          day   <= HOR_W'(1);
        end
        ST_FC_STEP: begin
          if (tot_n >= FC_W'(budget_limit)) begin
            hit <= 1'b1;
          end else if (day != hor) begin
            day   <= day + 1'b1;
            p     <= p + FC_W'(slope);
            total <= tot_n;
          end else begin
            day <= '0;
          end
        end
        ST_MUL: begin
          if (mb != '0) begin
            if (mb[0]) macc <= macc + ma;
            ma <= {ma[ALU_W-2:0], 1'b0};
            mb <= mb >> 1;
          end
        end
        ST_DIV: begin
          q     <= {q[Q_W-2:0], div_bit};
          rem   <= {rem_sub[ALU_W-2:0], 1'b0};
          steps <= steps - 1'b1;
        end
        ST_DONE: begin
          if (!out_valid) begin
            out_valid        <= 1'b1;
            fit_valid        <= n >= CNT_W'(3);
            trend_slope      <= slope[OUT_W-1:0];
            trend_intercept  <= icpt[OUT_W-1:0];
            fit_r2           <= r2;
            budget_exhausted <= hit;
            exhaustion_day   <= day;
            samples_used     <= n;
            overflow_flag    <= dropped;
            n                <= '0;
            sy               <= '0;
            sxy              <= '0;
            dropped          <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
